// ===== hdl/ckc_pkg.sv =====
// Shared constants and types for the canonical k-mer counter.
// No dependencies; used by canonical_kmer_counter_core.
package ckc_pkg;

    localparam int MAX_K     = 8;
    localparam int KEY_W     = 2 * MAX_K;
    localparam int COUNT_W   = 32;
    localparam int KLEN_W    = 4;
    localparam int SEEN_W    = $clog2(MAX_K + 1);
    localparam int SHAMT_W   = $clog2(KEY_W + 1);
    localparam int PADDR_W   = 3;

    localparam int IN_TDATA_W  = ((2 + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_W + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [KLEN_W-1:0]  KLEN_RESET  = KLEN_W'(4);
    localparam logic [KEY_W-1:0]   KEY_LAST    = '1;

    localparam logic [PADDR_W-1:0] REG_KMER_LENGTH = PADDR_W'(0);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// ===== hdl/canonical_kmer_counter_core.sv =====
// Canonical k-mer counter: base windows, count table memory and result register.
// Depends on ckc_pkg.
//
// After reset the block sweeps the 65536-entry count table to zero, one entry a
// cycle, and takes no input word until the sweep is done; the APB register can be
// written meanwhile. For a push that completes a k-mer, and for a count read, the
// table is read in the cycle the word is accepted; in the lookup state, once the
// output register is free, a push writes the updated count back and the result is
// loaded into the output register, since the table read is synchronous. A push
// during warm-up (fewer than k bases seen) is accepted and gives no word.
// The output register frees the input side as long as the result is taken.
module canonical_kmer_counter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ckc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // base[1:0], read_key[17:2]
    input  logic                               s_axis_tuser,  // action
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ckc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // kmer_key[15:0], kmer_count[47:16]
    output logic                               m_axis_tuser,  // is_read_reply
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ckc_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    ckc_pkg::t_state r_state, n_state;

    logic [ckc_pkg::KLEN_W-1:0]  r_kmer_length;
    logic [ckc_pkg::KEY_W-1:0]   r_fwd, n_fwd;
    logic [ckc_pkg::KEY_W-1:0]   r_rev, n_rev;
    logic [ckc_pkg::SEEN_W-1:0]  r_seen, n_seen;
    logic [ckc_pkg::KEY_W-1:0]   r_clr_addr;

    logic                        r_is_read;
    logic [ckc_pkg::KEY_W-1:0]   r_key;
    logic [ckc_pkg::COUNT_W-1:0] r_rd_data;

    logic                        r_out_valid;
    logic                        r_out_is_read;
    logic [ckc_pkg::KEY_W-1:0]   r_out_key;
    logic [ckc_pkg::COUNT_W-1:0] r_out_count;

    logic [ckc_pkg::COUNT_W-1:0] mem [2**ckc_pkg::KEY_W];

    logic                        w_fire_in;
    logic                        w_out_free;
    logic [1:0]                  w_base;
    logic [ckc_pkg::KEY_W-1:0]   w_read_key;
    logic [ckc_pkg::KLEN_W-1:0]  w_k;
    logic [ckc_pkg::SHAMT_W-1:0] w_shamt;
    logic [ckc_pkg::KEY_W-1:0]   w_fwd_k;
    logic [ckc_pkg::KEY_W-1:0]   w_rev_k;
    logic [ckc_pkg::KEY_W-1:0]   w_canon;
    logic                        w_kmer_ready;
    logic [ckc_pkg::COUNT_W-1:0] w_new_count;
    logic                        w_cfg_wr;

    logic                        mem_re;
    logic [ckc_pkg::KEY_W-1:0]   mem_raddr;
    logic                        mem_we;
    logic [ckc_pkg::KEY_W-1:0]   mem_waddr;
    logic [ckc_pkg::COUNT_W-1:0] mem_wdata;
    logic                        w_issue;
    logic                        w_finish;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ckc_pkg::REG_KMER_LENGTH);
    assign prdata   = (paddr == ckc_pkg::REG_KMER_LENGTH) ? 32'(r_kmer_length) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= ckc_pkg::KLEN_RESET;
        end else if (w_cfg_wr) begin
            r_kmer_length <= pwdata[ckc_pkg::KLEN_W-1:0];
        end
    end

    // window and key path
    assign w_fire_in  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_base     = s_axis_tdata[1:0];
    assign w_read_key = s_axis_tdata[ckc_pkg::KEY_W+1:2];

    always_comb begin
        if (r_kmer_length == '0) begin
            w_k = ckc_pkg::KLEN_W'(1);
        end else if (r_kmer_length > ckc_pkg::KLEN_W'(ckc_pkg::MAX_K)) begin
            w_k = ckc_pkg::KLEN_W'(ckc_pkg::MAX_K);
        end else begin
            w_k = r_kmer_length;
        end
    end

    assign n_fwd   = {r_fwd[ckc_pkg::KEY_W-3:0], w_base};
    assign n_rev   = {~w_base, r_rev[ckc_pkg::KEY_W-1:2]};
    assign n_seen  = (r_seen < ckc_pkg::SEEN_W'(ckc_pkg::MAX_K)) ? r_seen + 1'b1 : r_seen;
    assign w_shamt = ckc_pkg::SHAMT_W'(ckc_pkg::KEY_W) - {w_k[ckc_pkg::SHAMT_W-2:0], 1'b0};
    assign w_fwd_k = n_fwd & ~(ckc_pkg::KEY_LAST << {w_k[ckc_pkg::SHAMT_W-2:0], 1'b0});
    assign w_rev_k = n_rev >> w_shamt;
    assign w_canon = (w_fwd_k < w_rev_k) ? w_fwd_k : w_rev_k;
    assign w_kmer_ready = ckc_pkg::KLEN_W'(n_seen) >= w_k;

    assign w_new_count = (r_rd_data == ckc_pkg::COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ckc_pkg::ST_CLEAR: begin
                if (r_clr_addr == ckc_pkg::KEY_LAST) begin
                    n_state = ckc_pkg::ST_IDLE;
                end
            end
            ckc_pkg::ST_IDLE: begin
                if (w_fire_in && (s_axis_tuser == ckc_pkg::ACT_READ || w_kmer_ready)) begin
                    n_state = ckc_pkg::ST_LOOKUP;
                end
            end
            ckc_pkg::ST_LOOKUP: begin
                if (w_out_free) begin
                    n_state = ckc_pkg::ST_IDLE;
                end
            end
            default: n_state = ckc_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_issue       = 1'b0;
        w_finish      = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = w_read_key;
        mem_we        = 1'b0;
        mem_waddr     = r_key;
        mem_wdata     = w_new_count;
        case (r_state)
            ckc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ckc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_fire_in) begin
                    if (s_axis_tuser == ckc_pkg::ACT_READ) begin
                        w_issue = 1'b1;
                        mem_re  = 1'b1;
                    end else if (w_kmer_ready) begin
                        w_issue   = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = w_canon;
                    end
                end
            end
            ckc_pkg::ST_LOOKUP: begin
                if (w_out_free) begin
                    w_finish = 1'b1;
                    mem_we   = !r_is_read;
                end
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // count table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_fwd       <= '0;
            r_rev       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ckc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_fire_in && s_axis_tuser == ckc_pkg::ACT_PUSH) begin
                r_fwd  <= n_fwd;
                r_rev  <= n_rev;
                r_seen <= n_seen;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_is_read <= (s_axis_tuser == ckc_pkg::ACT_READ);
            r_key     <= (s_axis_tuser == ckc_pkg::ACT_READ) ? w_read_key : w_canon;
        end
        if (w_finish) begin
            r_out_is_read <= r_is_read;
            r_out_key     <= r_key;
            r_out_count   <= r_is_read ? r_rd_data : w_new_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_is_read;
    assign m_axis_tdata  = ckc_pkg::OUT_TDATA_W'({r_out_count, r_out_key});

    // checks
    a_no_table_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ckc_pkg::ST_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_no_output_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ckc_pkg::ST_CLEAR) |-> (!m_axis_tvalid && !s_axis_tready))
        else $error("traffic during table clear");

    a_read_goes_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire_in && s_axis_tuser == ckc_pkg::ACT_READ) |=> (r_state == ckc_pkg::ST_LOOKUP))
        else $error("read word not looked up");

    a_push_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == 1'b0)
        |-> (m_axis_tdata[ckc_pkg::KEY_W +: ckc_pkg::COUNT_W] != '0))
        else $error("counted k-mer reports zero");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for canonical_kmer_counter_core: stream words in, counts out.
// A directed table, then random phases across k-mer lengths, checked against a local count model.
// Depends on ckc_pkg and canonical_kmer_counter_core.
module tb;

    localparam int         N_PHASES     = 12;
    localparam int         PHASE_ITEMS  = 152;
    localparam int         PRESSURE_AT  = 700;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RECENT_DEPTH = 64;
    localparam longint     LIMIT_CYCLES = 700_000;

    localparam logic [1:0] B_A = 2'd0;
    localparam logic [1:0] B_C = 2'd1;
    localparam logic [1:0] B_G = 2'd2;
    localparam logic [1:0] B_T = 2'd3;

    localparam logic REPLY_COUNT = 1'b0;
    localparam logic REPLY_READ  = 1'b1;

    typedef struct packed {
        logic                      act;
        logic [1:0]                base;
        logic [ckc_pkg::KEY_W-1:0] key;
    } t_word;

    typedef struct packed {
        logic                        reply;
        logic [ckc_pkg::KEY_W-1:0]   key;
        logic [ckc_pkg::COUNT_W-1:0] count;
    } t_tally;

    typedef enum logic [1:0] {ROW_PUSH, ROW_READ, ROW_KLEN} t_row_kind;
    typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_GIVEN} t_row_out;

    typedef struct {
        t_row_kind                   kind;
        logic [1:0]                  base;
        logic [31:0]                 arg;
        t_row_out                    out;
        logic [ckc_pkg::KEY_W-1:0]   exp_key;
        logic [ckc_pkg::COUNT_W-1:0] exp_count;
    } t_row;

    localparam int N_ROWS = 28;

    t_row directed [N_ROWS] = '{
        '{ROW_READ, B_A, 32'h0000,     OUT_GIVEN, 16'h0000, 32'd0},
        '{ROW_READ, B_A, 32'hFFFF,     OUT_GIVEN, 16'hFFFF, 32'd0},
        '{ROW_PUSH, B_A, 32'h0000,     OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_A, 32'h0000,     OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_A, 32'h0000,     OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_A, 32'h0000,     OUT_GIVEN, 16'h0000, 32'd1},
        '{ROW_PUSH, B_A, 32'hFFFF,     OUT_GIVEN, 16'h0000, 32'd2},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_GIVEN, 16'h0000, 32'd3},
        '{ROW_READ, B_A, 32'h0000,     OUT_GIVEN, 16'h0000, 32'd3},
        '{ROW_KLEN, B_A, 32'd1,        OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_G, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_C, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_KLEN, B_A, 32'd8,        OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_C, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_G, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_KLEN, B_A, 32'd0,        OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_KLEN, B_A, 32'd15,       OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_A, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_T, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_READ, B_A, 32'h5555,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_KLEN, B_A, 32'hFFFFFFF3, OUT_NONE,  16'h0000, 32'd0},
        '{ROW_PUSH, B_C, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_PUSH, B_G, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0},
        '{ROW_READ, B_A, 32'h0000,     OUT_MODEL, 16'h0000, 32'd0}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [ckc_pkg::IN_TDATA_W-1:0]    s_axis_tdata;   // base[1:0], read_key[17:2]
    logic                              s_axis_tuser;   // action
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [ckc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;   // kmer_key[15:0], kmer_count[47:16]
    logic                              m_axis_tuser;   // is_read_reply
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ckc_pkg::PADDR_W-1:0]       paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    canonical_kmer_counter_core dut (.*);

    logic [ckc_pkg::KEY_W-1:0]   fwd_window;
    logic [ckc_pkg::KEY_W-1:0]   rev_window;
    int unsigned                 bases_seen;
    logic [ckc_pkg::KLEN_W-1:0]  kmer_len;
    logic [ckc_pkg::COUNT_W-1:0] tally [logic [ckc_pkg::KEY_W-1:0]];

    t_tally                      expected_tallies [$];
    logic [ckc_pkg::KEY_W-1:0]   recent_keys [$];

    int                 miss_count;
    int                 accepted;
    bit                 calm;
    bit                 hold_off;
    bit                 pressure_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("[canonical_kmer_counter_core] ERROR");
        $finish;
    end

    task automatic report_miss(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        miss_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    function automatic void expect_word(input t_tally r);
        expected_tallies.insert(expected_tallies.size(), r);
    endfunction

    function automatic bit count_kmer(input t_word w, output t_tally r);
        int unsigned                 k;
        logic [ckc_pkg::KEY_W-1:0]   fwd;
        logic [ckc_pkg::KEY_W-1:0]   rev;
        logic [ckc_pkg::KEY_W-1:0]   canon;
        logic [ckc_pkg::COUNT_W-1:0] c;
        r = '0;
        if (w.act == ckc_pkg::ACT_READ) begin
            c = tally.exists(w.key) ? tally[w.key] : '0;
            r = '{REPLY_READ, w.key, c};
            return 1'b1;
        end
        fwd_window = {fwd_window[ckc_pkg::KEY_W-3:0], w.base};
        rev_window = {2'd3 - w.base, rev_window[ckc_pkg::KEY_W-1:2]};
        if (bases_seen < ckc_pkg::MAX_K)
            bases_seen++;
        k = (kmer_len == 0) ? 1 : (kmer_len > ckc_pkg::MAX_K) ? ckc_pkg::MAX_K : kmer_len;
        if (bases_seen < k)
            return 1'b0;
        fwd   = fwd_window & ckc_pkg::KEY_W'((32'd1 << (2 * k)) - 1);
        rev   = rev_window >> (2 * (ckc_pkg::MAX_K - k));
        canon = (fwd < rev) ? fwd : rev;
        c     = tally.exists(canon) ? tally[canon] : '0;
        if (c != ckc_pkg::COUNT_MAX)
            c = c + 1'b1;
        tally[canon] = c;
        r = '{REPLY_COUNT, canon, c};
        return 1'b1;
    endfunction

    task automatic offer_word(input t_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ckc_pkg::IN_TDATA_W'({w.key, w.base});
        s_axis_tuser  <= w.act;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_kmer_length(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ckc_pkg::REG_KMER_LENGTH;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        kmer_len = value[ckc_pkg::KLEN_W-1:0];
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_tally got;
        t_tally want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = '{m_axis_tuser, m_axis_tdata[ckc_pkg::KEY_W-1:0],
                    m_axis_tdata[ckc_pkg::KEY_W +: ckc_pkg::COUNT_W]};
            if (expected_tallies.size() == 0) begin
                report_miss("unexpected word", 32'(got.key), got.count);
            end else begin
                want = expected_tallies.pop_front();
                if (got.reply !== want.reply)
                    report_miss("is_read_reply", 32'(got.reply), 32'(want.reply));
                if (got.key !== want.key)
                    report_miss("kmer_key", 32'(got.key), 32'(want.key));
                if (got.count !== want.count)
                    report_miss("kmer_count", got.count, want.count);
            end
        end
    end

    initial begin : result_side
        int burst;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!pressure_done && accepted >= PRESSURE_AT) begin
                hold_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off      = 1'b0;
                pressure_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
                m_axis_tready <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    initial begin : word_side
        t_row        row;
        t_word       w;
        t_tally      r;
        t_tally      given;
        bit          has;
        int          gap_odds;
        int          mpos;
        int          waited;
        logic [7:0]  motif;
        logic [3:0]  klen_pick;

        fwd_window    = '0;
        rev_window    = '0;
        bases_seen    = 0;
        kmer_len      = ckc_pkg::KLEN_RESET;
        miss_count    = 0;
        accepted      = 0;
        calm          = 1'b0;
        hold_off      = 1'b0;
        pressure_done = 1'b0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ckc_pkg::ACT_PUSH;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ckc_pkg::REG_KMER_LENGTH;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            row = directed[i];
            if (row.kind == ROW_KLEN) begin
                settle();
                write_kmer_length(row.arg);
            end else begin
                w.act  = (row.kind == ROW_READ) ? ckc_pkg::ACT_READ : ckc_pkg::ACT_PUSH;
                w.base = row.base;
                w.key  = row.arg[ckc_pkg::KEY_W-1:0];
                offer_word(w);
                accepted++;
                has = count_kmer(w, r);
                case (row.out)
                    OUT_MODEL: if (has) expect_word(r);
                    OUT_GIVEN: begin
                        given = '{(row.kind == ROW_READ) ? REPLY_READ : REPLY_COUNT,
                                  row.exp_key, row.exp_count};
                        expect_word(given);
                    end
                    default: ;
                endcase
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0:       klen_pick = 4'd1;
                1:       klen_pick = 4'd8;
                2:       klen_pick = 4'd0;
                3:       klen_pick = 4'd15;
                default: klen_pick = 4'($urandom_range(0, 15));
            endcase
            write_kmer_length({28'($urandom), klen_pick});
            calm     = (p == N_PHASES - 1);
            gap_odds = (p % 3 == 1) ? 0 : $urandom_range(5, 35);
            motif    = 8'($urandom);
            mpos     = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    w.act  = ckc_pkg::ACT_READ;
                    w.base = 2'($urandom);
                    if (recent_keys.size() != 0 && $urandom_range(0, 1) == 1)
                        w.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                    else
                        w.key = ckc_pkg::KEY_W'($urandom);
                end else begin
                    w.act = ckc_pkg::ACT_PUSH;
                    w.key = ckc_pkg::KEY_W'($urandom);
                    if ($urandom_range(0, 2) == 0) begin
                        w.base = motif[2*mpos +: 2];
                        mpos   = (mpos + 1) % 4;
                    end else begin
                        w.base = 2'($urandom);
                    end
                end
                offer_word(w);
                accepted++;
                if (count_kmer(w, r)) begin
                    expect_word(r);
                    if (r.reply == REPLY_COUNT) begin
                        recent_keys.insert(recent_keys.size(), r.key);
                        if (recent_keys.size() > RECENT_DEPTH)
                            void'(recent_keys.pop_front());
                    end
                end
                if (!calm && !hold_off && gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge i_clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_tallies.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_tallies.size() != 0)
            report_miss("missing words", 32'(expected_tallies.size()), 32'd0);

        if (miss_count == 0)
            $display("[canonical_kmer_counter_core] OK");
        else
            $display("[canonical_kmer_counter_core] ERROR");
        $finish;
    end

endmodule
